// ===== rtl/core/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types and constants of the bitmap chunk allocator: field widths,
// command and status codes, register indexes and default geometry.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int ADDR_W          = 32;
  localparam int REG_IDX_W       = 1;

  localparam int WORD_BITS_DEF   = 64;
  localparam int WORD_COUNT_DEF  = 64;
  localparam int CHUNK_SHIFT_DEF = 12;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_HEAP_BASE   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BREAK_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_GROW_REFUSED = 2'd2,
    ST_BAD_FREE     = 2'd3
  } status_t;

endpackage

// ===== rtl/core/bca_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// bca_bitmap_ram
// Bitmap word store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module bca_bitmap_ram #(
  parameter int W     = bca_pkg::WORD_BITS_DEF,
  parameter int DEPTH = bca_pkg::WORD_COUNT_DEF,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bca_bit_find.sv =====
// ----------------------------------------------------------------------------
// bca_bit_find
// Index of the lowest set bit of a word. The sequencer feeds it the inverted
// word to find a free chunk and the bit-reversed word to find the top chunk.
// ----------------------------------------------------------------------------
module bca_bit_find #(
  parameter int W  = bca_pkg::WORD_BITS_DEF,
  parameter int IW = $clog2(W)
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx
);

  logic [W-1:0] iso;

  // Two's complement isolates the lowest set bit as a one-hot word.
  assign iso   = vec & (~vec + W'(1));
  assign found = |vec;

  always_comb begin
    idx = '0;
    for (int i = 0; i < W; i++) begin
      if (iso[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

// ===== rtl/core/bitmap_chunk_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_chunk_allocator_top
// Allocate: the upward scan for the first word that is not full reads one
//   bitmap word per cycle.
// Free: the downward scan for the last word in use, when needed, reads one
//   word per cycle. One item at a time.
// After reset a clearing pass over every bitmap word runs with in_ready low.
// ----------------------------------------------------------------------------
module bitmap_chunk_allocator_top #(
  parameter int WORD_BITS   = bca_pkg::WORD_BITS_DEF,
  parameter int WORD_COUNT  = bca_pkg::WORD_COUNT_DEF,
  parameter int CHUNK_SHIFT = bca_pkg::CHUNK_SHIFT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [bca_pkg::ADDR_W-1:0]        in_free_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [bca_pkg::ADDR_W-1:0]        out_chunk_addr,
  output logic [bca_pkg::ADDR_W-1:0]        out_heap_break,
  input  logic                              cfg_we,
  input  logic [bca_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [bca_pkg::ADDR_W-1:0]        cfg_wdata
);

  localparam int AW     = bca_pkg::ADDR_W;
  localparam int WAW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int NCHUNK = WORD_COUNT * WORD_BITS;
  localparam int CIW    = $clog2(NCHUNK + 1);
  localparam int IXW    = AW - CHUNK_SHIFT;
  localparam int DIV_S  = CIW + BW;
  localparam int DIV_MW = CIW + 2;
  localparam int DIV_PW = CIW + DIV_MW;
  localparam int DIV_M  = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [WAW-1:0] LAST_W = WAW'(WORD_COUNT - 1);
  localparam logic [WORD_BITS-1:0] FULL = '1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_AL_SCAN, S_AL_FOUND, S_AL_LW,
    S_FR_CHK1, S_FR_CHK2, S_FR_DIV, S_FR_RD, S_FR_UPD, S_FR_SCAN,
    S_RZ_TOP, S_RZ_ADDR, S_RZ_DEC, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  logic [WAW-1:0]       scan_r, scan_nxt;
  logic                 iss_v_r, iss_v_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [WAW-1:0]       chk_w_r, chk_w_nxt;
  logic                 is_alloc_r, is_alloc_nxt;
  logic [AW-1:0]        addr_in_r, addr_in_nxt;
  logic [AW-1:0]        off_r, off_nxt;
  logic [CIW-1:0]       rem_r, rem_nxt;
  logic [WAW-1:0]       fw_w_r, fw_w_nxt;
  logic [WORD_BITS-1:0] fw_r, fw_nxt;
  logic [WORD_BITS-1:0] nw_r, nw_nxt;
  logic [CIW-1:0]       ci_al_r, ci_al_nxt;
  logic [WORD_BITS-1:0] rz_word_r, rz_word_nxt;
  logic [WAW-1:0]       rz_last_r, rz_last_nxt;
  logic [CIW-1:0]       rz_ci_r, rz_ci_nxt;
  logic [AW-1:0]        al_addr_r, al_addr_nxt;
  logic [AW-1:0]        target_r, target_nxt;
  logic [WAW-1:0]       last_r, last_nxt;
  logic [AW-1:0]        break_r, break_nxt;
  logic [AW-1:0]        base_r;
  logic [AW-1:0]        limit_r;
  bca_pkg::status_t     res_status_r, res_status_nxt;
  logic [AW-1:0]        res_addr_r, res_addr_nxt;
  logic [AW-1:0]        res_break_r, res_break_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bca_pkg::status_t     out_status_r, out_status_nxt;
  logic [AW-1:0]        out_addr_r, out_addr_nxt;
  logic [AW-1:0]        out_break_r, out_break_nxt;

  logic                 mem_we;
  logic [WAW-1:0]       mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WAW-1:0]       mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [WORD_BITS-1:0] bf_vec;
  logic                 bf_found;
  logic [BW-1:0]        bf_idx;
  logic [WORD_BITS-1:0] rz_rev;
  logic [CIW-1:0]       au_ci;
  logic [AW-1:0]        au_addr;
  logic [IXW-1:0]       free_ix;
  logic [WORD_BITS-1:0] fr_word;
  logic                 rz_ok;
  logic [DIV_PW-1:0]    div_prod;

  bca_bitmap_ram #(
    .W    (WORD_BITS),
    .DEPTH(WORD_COUNT),
    .AW   (WAW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bca_bit_find #(
    .W (WORD_BITS),
    .IW(BW)
  ) u_find (
    .vec  (bf_vec),
    .found(bf_found),
    .idx  (bf_idx)
  );

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      rz_rev[i] = rz_word_r[WORD_BITS-1-i];
    end
  end

  // The find unit and the address adder are shared between steps.
  assign bf_vec  = (state_r == S_AL_FOUND) ? ~fw_r : rz_rev;
  assign au_ci   = (state_r == S_RZ_TOP) ? ci_al_r : rz_ci_r;
  assign au_addr = base_r + (AW'(au_ci) << CHUNK_SHIFT);
  assign free_ix = off_r[AW-1:CHUNK_SHIFT];
  assign fr_word = mem_rdata & ~(WORD_BITS'(1) << rem_r[BW-1:0]);
  assign rz_ok   = (target_r == break_r) || (target_r <= limit_r);

  // Word index of a chunk by multiplying with the rounded-up reciprocal of
  // the word size; exact for every chunk index the map can hold.
  assign div_prod = DIV_PW'(rem_r) * DIV_PW'(DIV_M);

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_chunk_addr = out_addr_r;
  assign out_heap_break = out_break_r;

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    iss_v_nxt      = iss_v_r;
    chk_v_nxt      = chk_v_r;
    chk_w_nxt      = chk_w_r;
    is_alloc_nxt   = is_alloc_r;
    addr_in_nxt    = addr_in_r;
    off_nxt        = off_r;
    rem_nxt        = rem_r;
    fw_w_nxt       = fw_w_r;
    fw_nxt         = fw_r;
    nw_nxt         = nw_r;
    ci_al_nxt      = ci_al_r;
    rz_word_nxt    = rz_word_r;
    rz_last_nxt    = rz_last_r;
    rz_ci_nxt      = rz_ci_r;
    al_addr_nxt    = al_addr_r;
    target_nxt     = target_r;
    last_nxt       = last_r;
    break_nxt      = break_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_break_nxt  = res_break_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_break_nxt  = out_break_r;
    mem_we         = 1'b0;
    mem_waddr      = fw_w_r;
    mem_wdata      = nw_r;
    mem_raddr      = scan_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = scan_r;
        // Chunk 0 is reserved, so word 0 starts with its low bit set.
        mem_wdata = (scan_r == '0) ? WORD_BITS'(1) : '0;
        if (scan_r == LAST_W) begin
          scan_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + WAW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          is_alloc_nxt = (in_cmd == bca_pkg::CMD_ALLOC);
          addr_in_nxt  = in_free_addr;
          scan_nxt     = '0;
          iss_v_nxt    = 1'b1;
          chk_v_nxt    = 1'b0;
          state_nxt    = (in_cmd == bca_pkg::CMD_ALLOC) ? S_AL_SCAN : S_FR_CHK1;
        end
      end

      S_AL_SCAN: begin
        // Reads run one word ahead of the check of the word read last cycle.
        mem_raddr = scan_r;
        chk_v_nxt = iss_v_r;
        chk_w_nxt = scan_r;
        if (iss_v_r) begin
          if (scan_r == LAST_W) begin
            iss_v_nxt = 1'b0;
          end else begin
            scan_nxt = scan_r + WAW'(1);
          end
        end
        if (chk_v_r) begin
          if (mem_rdata != FULL) begin
            fw_nxt    = mem_rdata;
            fw_w_nxt  = chk_w_r;
            state_nxt = S_AL_FOUND;
          end else if (chk_w_r == LAST_W) begin
            res_status_nxt = bca_pkg::ST_NO_FREE;
            res_addr_nxt   = '0;
            res_break_nxt  = break_r;
            state_nxt      = S_RESP;
          end
        end
      end

      S_AL_FOUND: begin
        nw_nxt    = fw_r | (WORD_BITS'(1) << bf_idx);
        ci_al_nxt = CIW'(fw_w_r) * CIW'(WORD_BITS) + CIW'(bf_idx);
        mem_raddr = last_r;
        if (fw_w_r >= last_r) begin
          rz_word_nxt = fw_r | (WORD_BITS'(1) << bf_idx);
          rz_last_nxt = fw_w_r;
          state_nxt   = S_RZ_TOP;
        end else begin
          state_nxt = S_AL_LW;
        end
      end

      S_AL_LW: begin
        rz_word_nxt = mem_rdata;
        rz_last_nxt = last_r;
        state_nxt   = S_RZ_TOP;
      end

      S_FR_CHK1: begin
        if ((addr_in_r < base_r) || (addr_in_r >= break_r)) begin
          res_status_nxt = bca_pkg::ST_BAD_FREE;
          res_addr_nxt   = '0;
          res_break_nxt  = break_r;
          state_nxt      = S_RESP;
        end else begin
          off_nxt   = addr_in_r - base_r;
          state_nxt = S_FR_CHK2;
        end
      end

      S_FR_CHK2: begin
        if ((free_ix == '0) || (AW'(free_ix) >= AW'(NCHUNK))) begin
          res_status_nxt = bca_pkg::ST_BAD_FREE;
          res_addr_nxt   = '0;
          res_break_nxt  = break_r;
          state_nxt      = S_RESP;
        end else begin
          rem_nxt   = CIW'(free_ix);
          state_nxt = S_FR_DIV;
        end
      end

      S_FR_DIV: begin
        fw_w_nxt  = WAW'(div_prod >> DIV_S);
        state_nxt = S_FR_RD;
      end

      S_FR_RD: begin
        // The word is read while the bit position is left as the remainder.
        mem_raddr = fw_w_r;
        rem_nxt   = rem_r - CIW'(fw_w_r) * CIW'(WORD_BITS);
        state_nxt = S_FR_UPD;
      end

      S_FR_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = fw_w_r;
        mem_wdata = fr_word;
        if (last_r > fw_w_r) begin
          res_status_nxt = bca_pkg::ST_OK;
          res_addr_nxt   = '0;
          res_break_nxt  = break_r;
          state_nxt      = S_RESP;
        end else if ((fw_w_r == '0) || (fr_word != '0)) begin
          rz_word_nxt = fr_word;
          rz_last_nxt = fw_w_r;
          state_nxt   = S_RZ_TOP;
        end else begin
          scan_nxt  = fw_w_r - WAW'(1);
          iss_v_nxt = 1'b1;
          chk_v_nxt = 1'b0;
          state_nxt = S_FR_SCAN;
        end
      end

      S_FR_SCAN: begin
        mem_raddr = scan_r;
        chk_v_nxt = iss_v_r;
        chk_w_nxt = scan_r;
        if (iss_v_r) begin
          if (scan_r == '0) begin
            iss_v_nxt = 1'b0;
          end else begin
            scan_nxt = scan_r - WAW'(1);
          end
        end
        if (chk_v_r && ((mem_rdata != '0) || (chk_w_r == '0))) begin
          rz_word_nxt = mem_rdata;
          rz_last_nxt = chk_w_r;
          state_nxt   = S_RZ_TOP;
        end
      end

      S_RZ_TOP: begin
        // The top set bit of the last word marks where the break goes.
        rz_ci_nxt   = CIW'(rz_last_r) * CIW'(WORD_BITS) +
                      (bf_found ? (CIW'(WORD_BITS) - CIW'(bf_idx)) : '0);
        al_addr_nxt = au_addr;
        state_nxt   = S_RZ_ADDR;
      end

      S_RZ_ADDR: begin
        target_nxt = au_addr;
        state_nxt  = S_RZ_DEC;
      end

      S_RZ_DEC: begin
        res_addr_nxt  = '0;
        res_break_nxt = break_r;
        if (is_alloc_r) begin
          if (rz_ok) begin
            mem_we         = 1'b1;
            mem_waddr      = fw_w_r;
            mem_wdata      = nw_r;
            last_nxt       = rz_last_r;
            break_nxt      = target_r;
            res_status_nxt = bca_pkg::ST_OK;
            res_addr_nxt   = al_addr_r;
            res_break_nxt  = target_r;
          end else begin
            res_status_nxt = bca_pkg::ST_GROW_REFUSED;
          end
        end else begin
          // A refused shrink keeps the old break but still reports success.
          last_nxt       = rz_last_r;
          res_status_nxt = bca_pkg::ST_OK;
          if (rz_ok) begin
            break_nxt     = target_r;
            res_break_nxt = target_r;
          end
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_break_nxt  = res_break_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      scan_r      <= '0;
      iss_v_r     <= 1'b0;
      chk_v_r     <= 1'b0;
      last_r      <= '0;
      break_r     <= AW'(1) << CHUNK_SHIFT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      iss_v_r     <= iss_v_nxt;
      chk_v_r     <= chk_v_nxt;
      last_r      <= last_nxt;
      break_r     <= break_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_w_r      <= chk_w_nxt;
    is_alloc_r   <= is_alloc_nxt;
    addr_in_r    <= addr_in_nxt;
    off_r        <= off_nxt;
    rem_r        <= rem_nxt;
    fw_w_r       <= fw_w_nxt;
    fw_r         <= fw_nxt;
    nw_r         <= nw_nxt;
    ci_al_r      <= ci_al_nxt;
    rz_word_r    <= rz_word_nxt;
    rz_last_r    <= rz_last_nxt;
    rz_ci_r      <= rz_ci_nxt;
    al_addr_r    <= al_addr_nxt;
    target_r     <= target_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_break_r  <= res_break_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_break_r  <= out_break_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bca_pkg::REG_HEAP_BASE:   base_r  <= cfg_wdata;
        bca_pkg::REG_BREAK_LIMIT: limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/bca_checker.sv =====
// ----------------------------------------------------------------------------
// bca_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bca_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [bca_pkg::ADDR_W-1:0] out_chunk_addr,
  input logic [bca_pkg::ADDR_W-1:0] out_heap_break
);

  // The clearing pass keeps the input closed right after reset.
  a_init_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during the clearing pass");

  // An accepted item moves the block out of idle, so ready drops after accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an accepted item");

  // Only a successful allocate returns a chunk address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != bca_pkg::ST_OK)) |-> (out_chunk_addr == '0))
    else $error("failed request returned a chunk address");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_chunk_addr) &&
       $stable(out_heap_break)))
    else $error("stalled result changed");

endmodule

bind bitmap_chunk_allocator_top bca_checker u_bca_checker (.*);

// ===== tb/sv/tb_bitmap_chunk_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_chunk_allocator_top
// Self-checking bench for the bitmap chunk allocator. A scoreboard class keeps
// its own copy of the bitmap, the last word in use and the heap break, works
// out the result of every accepted request and compares it with what the
// block returns. Directed requests cover rejected frees, refused grows and
// address wrap. Random phases with different base and limit settings follow,
// with two full drains of the heap among them.
// ----------------------------------------------------------------------------
module tb_bitmap_chunk_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W      = bca_pkg::ADDR_W;
  localparam int REG_IDX_W   = bca_pkg::REG_IDX_W;
  localparam int WORD_BITS   = bca_pkg::WORD_BITS_DEF;
  localparam int WORD_COUNT  = bca_pkg::WORD_COUNT_DEF;
  localparam int CHUNK_SHIFT = bca_pkg::CHUNK_SHIFT_DEF;
  localparam int CHUNKS      = WORD_BITS * WORD_COUNT;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    bca_pkg::status_t  status;
    logic [ADDR_W-1:0] chunk_addr;
    logic [ADDR_W-1:0] heap_break;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [WORD_BITS-1:0] bitmap [WORD_COUNT];
    int                   top_word;
    logic [ADDR_W-1:0]    brk;
    logic [ADDR_W-1:0]    base;
    logic [ADDR_W-1:0]    limit;
    alloc_result_t        expected_q[$];
    int                   errors;
    int                   n_alloc;
    int                   n_free;
    int                   n_status [4];

    function void reset_state();
      foreach (bitmap[i]) bitmap[i] = '0;
      bitmap[0] = 1;
      top_word  = 0;
      base      = '0;
      limit     = '1;
      brk       = chunk_addr(1);
      expected_q.delete();
    endfunction

    function logic [ADDR_W-1:0] chunk_addr(int idx);
      return base + ADDR_W'(idx << CHUNK_SHIFT);
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      if (idx == bca_pkg::REG_HEAP_BASE) base = value;
      else limit = value;
    endfunction

    // Puts the break just past the top set bit of the last word in use, unless the limit refuses it.
    function bit move_break();
      int                top_bit;
      logic [ADDR_W-1:0] target;
      top_bit = 0;
      for (int i = 0; i < WORD_BITS; i++) if (bitmap[top_word][i]) top_bit = i + 1;
      target = chunk_addr(top_word * WORD_BITS + top_bit);
      if (target == brk) return 1;
      if (target <= limit) begin
        brk = target;
        return 1;
      end
      return 0;
    endfunction

    function bca_pkg::status_t take_chunk(output logic [ADDR_W-1:0] addr);
      int                   w;
      int                   b;
      int                   prev_top;
      logic [WORD_BITS-1:0] word;
      addr = '0;
      w    = 0;
      while (w < WORD_COUNT && bitmap[w] == '1) w++;
      if (w == WORD_COUNT) return bca_pkg::ST_NO_FREE;
      word = bitmap[w];
      b    = 0;
      while (word[b]) b++;
      bitmap[w][b] = 1'b1;
      prev_top     = top_word;
      if (w > top_word) top_word = w;
      if (!move_break()) begin
        bitmap[w] = word;
        top_word  = prev_top;
        return bca_pkg::ST_GROW_REFUSED;
      end
      addr = chunk_addr(w * WORD_BITS + b);
      return bca_pkg::ST_OK;
    endfunction

    function bca_pkg::status_t release_chunk(logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] idx;
      int                w;
      if (addr < base || addr >= brk) return bca_pkg::ST_BAD_FREE;
      idx = (addr - base) >> CHUNK_SHIFT;
      if (idx == 0 || idx >= CHUNKS) return bca_pkg::ST_BAD_FREE;
      w = int'(idx) / WORD_BITS;
      bitmap[w][int'(idx) % WORD_BITS] = 1'b0;
      if (top_word > w) return bca_pkg::ST_OK;
      // Walk down to the highest word that still holds a chunk.
      while (w > 0 && bitmap[w] == '0) w--;
      top_word = w;
      void'(move_break());
      return bca_pkg::ST_OK;
    endfunction

    function void note_request(logic cmd, logic [ADDR_W-1:0] addr);
      alloc_result_t r;
      r.chunk_addr = '0;
      if (cmd == bca_pkg::CMD_ALLOC) begin
        r.status = take_chunk(r.chunk_addr);
        n_alloc++;
      end else begin
        r.status = release_chunk(addr);
        n_free++;
      end
      r.heap_break = brk;
      n_status[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [ADDR_W-1:0] chunk,
                               logic [ADDR_W-1:0] heap_break);
      alloc_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding: status %0d addr %h break %h",
                 $time, status, chunk, heap_break);
        return;
      end
      r = expected_q.pop_front();
      if (status !== r.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
      end
      if (chunk !== r.chunk_addr) begin
        errors++;
        $display("%0t: chunk_addr expected %h actual %h", $time, r.chunk_addr, chunk);
      end
      if (heap_break !== r.heap_break) begin
        errors++;
        $display("%0t: heap_break expected %h actual %h", $time, r.heap_break, heap_break);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic [ADDR_W-1:0]    in_free_addr;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_status;
  logic [ADDR_W-1:0]    out_chunk_addr;
  logic [ADDR_W-1:0]    out_heap_break;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;

  alloc_scoreboard sb = new();
  bit              calm;
  int              reg_writes;
  int              stall_cycles;

  bitmap_chunk_allocator_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_free_addr   (in_free_addr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_chunk_addr (out_chunk_addr),
    .out_heap_break (out_heap_break),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_status, out_chunk_addr, out_heap_break);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Holds valid across back-to-back items; drops it only for a random gap.
  task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 14);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_free_addr <= addr;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, addr);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
    reg_writes++;
  endtask

  // Mostly chunks inside the current heap, the rest aimed at each reject path.
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    int unsigned       span;
    int unsigned       roll;
    logic [ADDR_W-1:0] offset;
    roll = $urandom_range(0, 99);
    span = (sb.brk - sb.base) >> CHUNK_SHIFT;
    if (span > CHUNKS) span = CHUNKS;
    offset = $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, (1 << CHUNK_SHIFT) - 1)) : '0;
    if (roll < 70 && span >= 2)
      return sb.base + ADDR_W'($urandom_range(1, span - 1) << CHUNK_SHIFT) + offset;
    if (roll < 80) return sb.base + offset;
    if (roll < 90) return sb.brk + ADDR_W'($urandom_range(0, 8 << CHUNK_SHIFT));
    return $urandom();
  endfunction

  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit,
                           input int n_items, input int alloc_pct);
    wait_idle();
    write_reg(bca_pkg::REG_HEAP_BASE, base);
    write_reg(bca_pkg::REG_BREAK_LIMIT, limit);
    repeat (n_items) begin
      if ($urandom_range(0, 59) == 0) wait_idle();
      if ($urandom_range(0, 99) < alloc_pct) send_request(bca_pkg::CMD_ALLOC, $urandom());
      else send_request(bca_pkg::CMD_FREE, pick_free_addr());
    end
  endtask

  // Frees every chunk up to the end of the last word in use, lowest first,
  // so the final frees empty the upper words and the scan falls to word 0.
  task automatic drain_heap();
    int last_idx;
    last_idx = (sb.top_word + 1) * WORD_BITS - 1;
    for (int i = 1; i <= last_idx; i++) begin
      send_request(bca_pkg::CMD_FREE, sb.base + ADDR_W'(i << CHUNK_SHIFT));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = bca_pkg::CMD_ALLOC;
    in_free_addr = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = bca_pkg::REG_HEAP_BASE;
    cfg_wdata    = '0;
    calm         = 1'b0;
    reg_writes   = 0;
    stall_cycles = 0;
    sb.reset_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset register values.
    write_reg(bca_pkg::REG_HEAP_BASE, '0);
    write_reg(bca_pkg::REG_BREAK_LIMIT, '1);
    repeat (3) send_request(bca_pkg::CMD_ALLOC, $urandom());
    send_request(bca_pkg::CMD_FREE, 32'h0000_0800);  // inside the reserved chunk
    send_request(bca_pkg::CMD_FREE, 32'hFFFF_FFFF);  // far above the break
    send_request(bca_pkg::CMD_FREE, sb.brk);         // exactly at the break
    send_request(bca_pkg::CMD_FREE, 32'h0000_2ABC);  // unaligned address in chunk 2
    send_request(bca_pkg::CMD_FREE, 32'h0000_2000);  // chunk 2 again, already clear
    send_request(bca_pkg::CMD_ALLOC, $urandom());    // first fit hands chunk 2 back
    send_request(bca_pkg::CMD_FREE, 32'h0000_3000);  // top chunk, break comes down
    wait_idle();
    write_reg(bca_pkg::REG_BREAK_LIMIT, sb.brk);
    send_request(bca_pkg::CMD_ALLOC, $urandom());    // grow past the limit
    wait_idle();
    write_reg(bca_pkg::REG_BREAK_LIMIT, sb.brk + 32'h0000_1000);
    send_request(bca_pkg::CMD_ALLOC, $urandom());
    wait_idle();
    write_reg(bca_pkg::REG_BREAK_LIMIT, '0);
    send_request(bca_pkg::CMD_FREE, 32'h0000_3000);  // shrink refused, break stays
    send_request(bca_pkg::CMD_ALLOC, $urandom());    // target equals break, limit ignored
    wait_idle();
    write_reg(bca_pkg::REG_HEAP_BASE, 32'hFFFF_F000);
    write_reg(bca_pkg::REG_BREAK_LIMIT, '1);
    send_request(bca_pkg::CMD_FREE, 32'h0000_1000);  // below the base
    send_request(bca_pkg::CMD_ALLOC, $urandom());    // chunk address wraps past zero
    wait_idle();
    write_reg(bca_pkg::REG_HEAP_BASE, 32'h8000_0000);
    send_request(bca_pkg::CMD_ALLOC, $urandom());
    wait_idle();
    write_reg(bca_pkg::REG_HEAP_BASE, 32'h7000_0000);
    send_request(bca_pkg::CMD_FREE, 32'h7100_0000);  // below the break but past the map
    send_request(bca_pkg::CMD_FREE, 32'h7000_3000);

    // Random phases; the first one runs without random input gaps or output stalls.
    calm = 1'b1;
    run_phase('0, '1, 180, 65);
    drain_heap();
    calm = 1'b0;
    run_phase(32'h1234_5000, 32'h1234_5000 + 32'(48 << CHUNK_SHIFT), 150, 60);
    run_phase(32'hFFFF_0000, '1, 150, 55);
    drain_heap();
    run_phase($urandom(), $urandom(), 120, 55);
    run_phase('0, '0, 60, 50);
    run_phase(32'h0040_0000, '1, 150, 60);

    wait_idle();
    repeat (2 * WORD_COUNT + 16) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    $display("Ran %0d allocates and %0d frees across %0d register writes.",
             sb.n_alloc, sb.n_free, reg_writes);
    $display("Outcomes: %0d ok, %0d map full, %0d grow refused, %0d rejected frees.",
             sb.n_status[bca_pkg::ST_OK], sb.n_status[bca_pkg::ST_NO_FREE],
             sb.n_status[bca_pkg::ST_GROW_REFUSED], sb.n_status[bca_pkg::ST_BAD_FREE]);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
